@@ sv/hak_pkg.sv @@
// Shared types and constants of the HID array key diff block.
// Used by the front part, the back part and the top level; depends on nothing.
`default_nettype none

package hak_pkg;

  // Width of one array slot value and of a usage index.
  localparam int unsigned VALUE_W = 16;

  // Width of the slot count register.
  localparam int unsigned SLOT_CNT_W = 3;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOGICAL_MIN = 2'd0;
  localparam logic [1:0] REG_LOGICAL_MAX = 2'd1;
  localparam logic [1:0] REG_USAGE_COUNT = 2'd2;
  localparam logic [1:0] REG_SLOT_COUNT  = 2'd3;

  // Kind of one result item.
  typedef enum logic [1:0] {
    EV_RELEASE = 2'd0,
    EV_PRESS   = 2'd1,
    EV_SYNC    = 2'd2
  } event_kind_t;

  // One result item as it sits in the result queue.
  typedef struct packed {
    event_kind_t          kind;
    logic [VALUE_W-1:0]   usage_offset;
    logic                 end_of_run;
  } result_t;

  // Range settings that decide whether a value names a usage.
  typedef struct packed {
    logic signed [VALUE_W-1:0] logical_min;
    logic signed [VALUE_W-1:0] logical_max;
    logic [VALUE_W-1:0]        usage_count;
  } range_cfg_t;

endpackage

`default_nettype wire

@@ sv/hak_fifo.sv @@
// Small register-based queue used between the front and back parts and
// in front of the result ports. Depends on nothing.
`default_nettype none

module hak_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill == NW'(DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/hak_front.sv @@
// Front part: accepts slot items, decides which slot each one fills and
// hands a command to the back part. Depends on hak_pkg.
`default_nettype none

module hak_front #(
  parameter int unsigned MAX_SLOTS = 6
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  input  wire logic signed [hak_pkg::VALUE_W-1:0] slot_value,
  input  wire logic                               last,
  input  wire logic [$clog2(MAX_SLOTS+1)-1:0]     active_slots,
  input  wire logic                               cmd_full,
  output logic                                    cmd_push,
  output logic [hak_pkg::VALUE_W+2+$clog2(MAX_SLOTS+1)-1:0] cmd_data
);

  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  logic [CW-1:0] load_position;
  logic          slot_free;

  // A slot is taken only while the report still has room for it.
  assign slot_free = (load_position < active_slots);
  assign cmd_push  = push && !cmd_full;
  assign cmd_data  = {slot_value, last, slot_free, load_position};

  // Load position advances per stored slot and restarts after last.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
    end else if (cmd_push) begin
      if (last) begin
        load_position <= '0;
      end else if (slot_free) begin
        load_position <= load_position + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/hak_back.sv @@
// Back part: stores slot commands, and on the last slot walks the slots,
// checks validity and presence, and queues release, press and sync items.
// Depends on hak_pkg.
`default_nettype none

module hak_back #(
  parameter int unsigned MAX_SLOTS = 6
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire hak_pkg::range_cfg_t            range_cfg,
  input  wire logic [$clog2(MAX_SLOTS+1)-1:0] active_slots,
  input  wire logic                           cmd_empty,
  input  wire logic [hak_pkg::VALUE_W+2+$clog2(MAX_SLOTS+1)-1:0] cmd_data,
  output logic                                cmd_pop,
  input  wire logic                           out_full,
  output logic                                out_push,
  output hak_pkg::result_t                    out_item
);

  localparam int unsigned VW = hak_pkg::VALUE_W;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_REL  = 5'b00100,
    ST_PRS  = 5'b01000,
    ST_SYNC = 5'b10000
  } state_t;

  state_t        state;
  logic [VW-1:0] previous_keys [MAX_SLOTS];
  logic [VW-1:0] incoming_keys [MAX_SLOTS];
  logic [CW-1:0] slot;
  logic          rel_hit;
  logic          prs_hit;
  logic [VW-1:0] rel_off;
  logic [VW-1:0] prs_off;

  // Command fields.
  logic [VW-1:0] cmd_value;
  logic          cmd_last;
  logic          cmd_write;
  logic [CW-1:0] cmd_pos;
  logic [CW-1:0] cmd_next_pos;

  assign {cmd_value, cmd_last, cmd_write, cmd_pos} = cmd_data;
  assign cmd_next_pos = cmd_write ? cmd_pos + CW'(1) : cmd_pos;
  assign cmd_pop      = (state == ST_LOAD) && !cmd_empty;

  // Validity check: min <= v <= max and v - min below the usage count.
  function automatic logic value_valid(input logic [VW-1:0] raw,
                                       input hak_pkg::range_cfg_t cfg);
    logic [VW:0] diff;
    logic        le;
    diff = {raw[VW-1], raw} - {cfg.logical_min[VW-1], cfg.logical_min};
    le   = ($signed(raw) <= cfg.logical_max);
    return !diff[VW] && le && (diff[VW-1:0] < cfg.usage_count);
  endfunction

  // Slot compare: both values of the current slot against the other list.
  logic [VW-1:0] old_v;
  logic [VW-1:0] new_v;
  logic          old_in_new;
  logic          new_in_old;

  always_comb begin
    old_v      = previous_keys[slot[IW-1:0]];
    new_v      = incoming_keys[slot[IW-1:0]];
    old_in_new = 1'b0;
    new_in_old = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (CW'(i) < active_slots) begin
        old_in_new = old_in_new | (incoming_keys[i] == old_v);
        new_in_old = new_in_old | (previous_keys[i] == new_v);
      end
    end
  end

  // Result item offered to the result queue in each emitting state.
  always_comb begin
    out_push = 1'b0;
    out_item = '{kind: hak_pkg::EV_SYNC, usage_offset: '0, end_of_run: 1'b1};
    unique case (state)
      ST_REL: begin
        out_push = rel_hit && !out_full;
        out_item = '{kind: hak_pkg::EV_RELEASE, usage_offset: rel_off,
                     end_of_run: 1'b0};
      end
      ST_PRS: begin
        out_push = prs_hit && !out_full;
        out_item = '{kind: hak_pkg::EV_PRESS, usage_offset: prs_off,
                     end_of_run: 1'b0};
      end
      ST_SYNC: begin
        out_push = !out_full;
      end
      ST_LOAD, ST_CMP: begin
        out_push = 1'b0;
      end
      default: begin
        out_push = 1'b0;
      end
    endcase
  end

  // Sequencer and previous list.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      slot  <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        previous_keys[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (cmd_pop && cmd_last) begin
            slot  <= '0;
            state <= (active_slots == '0) ? ST_SYNC : ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_REL;
        end
        ST_REL: begin
          if (!rel_hit || !out_full) begin
            state <= ST_PRS;
          end
        end
        ST_PRS: begin
          if (!prs_hit || !out_full) begin
            if (slot + CW'(1) == active_slots) begin
              state <= ST_SYNC;
            end else begin
              slot  <= slot + CW'(1);
              state <= ST_CMP;
            end
          end
        end
        ST_SYNC: begin
          if (!out_full) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
              if (CW'(i) < active_slots) begin
                previous_keys[i] <= incoming_keys[i];
              end
            end
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Compare flags and offsets of the current slot.
  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      rel_hit <= value_valid(old_v, range_cfg) && !old_in_new;
      prs_hit <= value_valid(new_v, range_cfg) && !new_in_old;
      rel_off <= old_v - range_cfg.logical_min;
      prs_off <= new_v - range_cfg.logical_min;
    end
  end

  // Incoming list: slot writes, and zero fill of missing slots on last.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (cmd_write && (CW'(i) == cmd_pos)) begin
          incoming_keys[i] <= cmd_value;
        end else if (cmd_last && (CW'(i) >= cmd_next_pos) &&
                     (CW'(i) < active_slots)) begin
          incoming_keys[i] <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/hid_array_key_diff.sv @@
// Top level of the HID array key diff block: configuration registers,
// front part, command queue, back part and result queue.
// Depends on hak_pkg, hak_fifo, hak_front and hak_back.
`default_nettype none

// The slot values of one report enter one per item; the item with last set
// closes the report. For a closing item the back part's slot sequencer
// compares each slot against both lists and then offers its release and
// its press; stalls on the result side hold it. A two-entry command queue
// lets the next report start to load while the previous one is still
// compared, and a two-entry result queue holds finished items until they
// are popped. Each report yields releases and presses in slot order and
// then one sync item with end_of_run set. Slot counts above MAX_SLOTS act
// as MAX_SLOTS.

module hid_array_key_diff #(
  parameter int unsigned MAX_SLOTS = 6
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic signed [hak_pkg::VALUE_W-1:0] slot_value,
  input  wire logic                               last,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [1:0]                              event_kind,
  output logic [hak_pkg::VALUE_W-1:0]             usage_offset,
  output logic                                    end_of_run,
  input  wire logic                               wr_en,
  input  wire logic [1:0]                         wr_index,
  input  wire logic [hak_pkg::VALUE_W-1:0]        wr_data
);

  localparam int unsigned CW    = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CMD_W = hak_pkg::VALUE_W + 2 + CW;
  localparam int unsigned RES_W = $bits(hak_pkg::result_t);

  hak_pkg::range_cfg_t              range_cfg;
  logic [hak_pkg::SLOT_CNT_W-1:0]   slot_count;
  logic [CW-1:0]                    active_slots;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_cfg.logical_min <= 16'sd0;
      range_cfg.logical_max <= 16'sd255;
      range_cfg.usage_count <= 16'd256;
      slot_count            <= 3'd6;
    end else if (wr_en) begin
      unique case (wr_index)
        hak_pkg::REG_LOGICAL_MIN: range_cfg.logical_min <= wr_data;
        hak_pkg::REG_LOGICAL_MAX: range_cfg.logical_max <= wr_data;
        hak_pkg::REG_USAGE_COUNT: range_cfg.usage_count <= wr_data;
        hak_pkg::REG_SLOT_COUNT:  slot_count <= wr_data[hak_pkg::SLOT_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Slot count saturated to the storage depth.
  assign active_slots = (32'(slot_count) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(slot_count);

  logic             cmd_push;
  logic [CMD_W-1:0] cmd_wdata;
  logic             cmd_full;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_rdata;
  logic             cmd_empty;

  hak_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .slot_value   (slot_value),
    .last         (last),
    .active_slots (active_slots),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_wdata)
  );

  assign full = cmd_full;

  hak_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_wdata),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_rdata),
    .empty     (cmd_empty)
  );

  logic             res_push;
  hak_pkg::result_t res_item;
  logic             res_full;
  hak_pkg::result_t res_head;
  logic [RES_W-1:0] res_head_bits;

  hak_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .range_cfg    (range_cfg),
    .active_slots (active_slots),
    .cmd_empty    (cmd_empty),
    .cmd_data     (cmd_rdata),
    .cmd_pop      (cmd_pop),
    .out_full     (res_full),
    .out_push     (res_push),
    .out_item     (res_item)
  );

  hak_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_item),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_head_bits),
    .empty     (empty)
  );

  // Result ports show the oldest queued item.
  assign res_head     = hak_pkg::result_t'(res_head_bits);
  assign event_kind   = res_head.kind;
  assign usage_offset = res_head.usage_offset;
  assign end_of_run   = res_head.end_of_run;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for hid_array_key_diff: drives report slots through
// the push side, predicts release, press and sync items, and checks every pop.
// Depends on hak_pkg and the hid_array_key_diff RTL.

module testbench;

  localparam int SETTLE = 64;      // cycles allowed for the back part to go quiet
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 42;

  // One slot of a report as it waits to be pushed.
  typedef struct {
    logic [hak_pkg::VALUE_W-1:0] value;
    logic                        last;
  } slot_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [hak_pkg::VALUE_W-1:0] slot_value = '0;
  logic last = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] event_kind;
  logic [hak_pkg::VALUE_W-1:0] usage_offset;
  logic end_of_run;
  logic wr_en = 1'b0;
  logic [1:0] wr_index = '0;
  logic [hak_pkg::VALUE_W-1:0] wr_data = '0;

  // Stimulus and scoreboard state.
  slot_item_t slot_queue[$];
  hak_pkg::result_t key_events[$];
  int queued = 0;
  int accepted = 0;
  int errors = 0;
  int idle_cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit item_taken = 1'b0;

  // Predictor copy of the registers and key lists.
  logic signed [hak_pkg::VALUE_W-1:0] cfg_min = 16'sd0;
  logic signed [hak_pkg::VALUE_W-1:0] cfg_max = 16'sd255;
  logic [hak_pkg::VALUE_W-1:0] cfg_usages = 16'd256;
  logic [hak_pkg::SLOT_CNT_W-1:0] cfg_slots = 3'd6;
  logic [hak_pkg::VALUE_W-1:0] held_keys[6] = '{default: '0};
  logic [hak_pkg::VALUE_W-1:0] new_keys[6] = '{default: '0};
  int load_pos = 0;

  hid_array_key_diff DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .slot_value(slot_value),
    .last(last), .empty(empty), .pop(pop), .event_kind(event_kind),
    .usage_offset(usage_offset), .end_of_run(end_of_run), .wr_en(wr_en),
    .wr_index(wr_index), .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  function automatic int live_slots();
    return (cfg_slots > 3'd6) ? 6 : int'(cfg_slots);
  endfunction

  // A value names a usage when it lies in min..max and its offset is below the count.
  function automatic bit names_usage(logic [hak_pkg::VALUE_W-1:0] raw);
    int v;
    v = $signed(raw);
    return v >= int'(cfg_min) && v <= int'(cfg_max) &&
           (v - int'(cfg_min)) < int'(cfg_usages);
  endfunction

  function automatic logic [hak_pkg::VALUE_W-1:0] usage_of(
      logic [hak_pkg::VALUE_W-1:0] raw);
    int d;
    d = int'($signed(raw)) - int'(cfg_min);
    return d[hak_pkg::VALUE_W-1:0];
  endfunction

  // Searches the new list or the held list for a raw value.
  function automatic bit listed(bit in_new, logic [hak_pkg::VALUE_W-1:0] raw,
                                int count);
    for (int i = 0; i < count; i++) begin
      if ((in_new ? new_keys[i] : held_keys[i]) == raw) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Loads one slot and, when it closes the report, queues the key changes.
  task automatic diff_report_slot(logic [hak_pkg::VALUE_W-1:0] value, logic closes);
    int count;
    count = live_slots();
    if (load_pos < count) begin
      new_keys[load_pos] = value;
      load_pos++;
    end
    if (!closes) return;
    for (int n = load_pos; n < count; n++) new_keys[n] = '0;
    for (int n = 0; n < count; n++) begin
      if (names_usage(held_keys[n]) && !listed(1'b1, held_keys[n], count))
        key_events.push_back('{hak_pkg::EV_RELEASE, usage_of(held_keys[n]), 1'b0});
      if (names_usage(new_keys[n]) && !listed(1'b0, new_keys[n], count))
        key_events.push_back('{hak_pkg::EV_PRESS, usage_of(new_keys[n]), 1'b0});
    end
    key_events.push_back('{hak_pkg::EV_SYNC, '0, 1'b1});
    for (int n = 0; n < count; n++) held_keys[n] = new_keys[n];
    load_pos = 0;
  endtask

  // Monitor: predicts on accepted slots, checks popped items, runs the watchdog.
  always @(posedge clk) begin
    bit busy;
    hak_pkg::result_t want;
    busy = 1'b0;
    item_taken = 1'b0;
    if (!rst) begin
      if (push && !full) begin
        item_taken = 1'b1;
        accepted++;
        busy = 1'b1;
        diff_report_slot(slot_value, last);
      end
      if (pop && !empty) begin
        busy = 1'b1;
        if (key_events.size() == 0) begin
          errors++;
          $error("unexpected item: event_kind %0d usage_offset %0d end_of_run %0d",
                 event_kind, usage_offset, end_of_run);
        end else begin
          want = key_events.pop_front();
          if (event_kind !== want.kind) begin
            errors++;
            $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
          end
          if (usage_offset !== want.usage_offset) begin
            errors++;
            $error("usage_offset: expected %0d, got %0d", want.usage_offset,
                   usage_offset);
          end
          if (end_of_run !== want.end_of_run) begin
            errors++;
            $error("end_of_run: expected %0d, got %0d", want.end_of_run, end_of_run);
          end
        end
      end
      if (wr_en) busy = 1'b1;
      if (busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Driver: holds a slot until it is taken, then offers the next or idles.
  always @(negedge clk) begin
    slot_item_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || item_taken) begin
      if (slot_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        nxt = slot_queue.pop_front();
        push <= 1'b1;
        slot_value <= nxt.value;
        last <= nxt.last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side: stalls at random at the current rate.
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_stall);
  end

  task automatic add_slot(int value, bit closes);
    slot_queue.push_back('{value[hak_pkg::VALUE_W-1:0], closes});
    queued++;
  endtask

  // Waits until every slot is taken and every item has come, then lets the block settle.
  task automatic drain();
    while (accepted != queued || key_events.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data[hak_pkg::VALUE_W-1:0];
    @(posedge clk);
    case (idx)
      hak_pkg::REG_LOGICAL_MIN: cfg_min = data[hak_pkg::VALUE_W-1:0];
      hak_pkg::REG_LOGICAL_MAX: cfg_max = data[hak_pkg::VALUE_W-1:0];
      hak_pkg::REG_USAGE_COUNT: cfg_usages = data[hak_pkg::VALUE_W-1:0];
      hak_pkg::REG_SLOT_COUNT:  cfg_slots = data[hak_pkg::SLOT_CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Slot values cluster near the range edges so that keys repeat between reports.
  function automatic int pick_value();
    int p;
    p = $urandom_range(99);
    if (p < 12) return int'($urandom);
    if (p < 20) return 0;
    if (p < 28) return int'(cfg_max) + int'($urandom_range(0, 2)) - 1;
    return int'(cfg_min) + int'($urandom_range(0, 12));
  endfunction

  // Mostly full reports; some short ones and some with extra slots.
  task automatic add_random_report();
    int count;
    int len;
    int p;
    count = live_slots();
    if (count == 0) count = 1;
    p = $urandom_range(99);
    if (p < 70) len = count;
    else if (p < 85) len = $urandom_range(1, count);
    else len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) add_slot(pick_value(), i == len - 1);
  endtask

  task automatic random_config();
    int lo;
    int hi;
    int p;
    p = $urandom_range(9);
    if (p < 6) lo = int'($urandom_range(0, 60)) - 30;
    else if (p < 8) lo = 0;
    else if (p == 8) lo = -32768;
    else lo = 32700;
    p = $urandom_range(9);
    if (p < 7) hi = lo + int'($urandom_range(0, 30));
    else if (p < 9) hi = 32767;
    else hi = lo - 1;
    if (hi > 32767) hi = 32767;
    if (hi < -32768) hi = -32768;
    write_reg(hak_pkg::REG_LOGICAL_MIN, lo);
    write_reg(hak_pkg::REG_LOGICAL_MAX, hi);
    p = $urandom_range(9);
    if (p < 5) write_reg(hak_pkg::REG_USAGE_COUNT, $urandom_range(1, 30));
    else if (p < 7) write_reg(hak_pkg::REG_USAGE_COUNT, 256);
    else if (p < 9) write_reg(hak_pkg::REG_USAGE_COUNT, 65535);
    else write_reg(hak_pkg::REG_USAGE_COUNT, 0);
    p = $urandom_range(9);
    if (p < 8) write_reg(hak_pkg::REG_SLOT_COUNT, $urandom_range(1, 6));
    else if (p == 8) write_reg(hak_pkg::REG_SLOT_COUNT, 0);
    else write_reg(hak_pkg::REG_SLOT_COUNT, 7);
  endtask

  initial begin
    int start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full report with new keys, then a short report padded with zeros.
    add_slot(4, 0); add_slot(5, 0); add_slot(6, 0);
    add_slot(0, 0); add_slot(0, 0); add_slot(0, 1);
    add_slot(5, 0); add_slot(7, 1);
    // Field extremes and one extra slot past the slot count.
    add_slot(-32768, 0); add_slot(32767, 0); add_slot(255, 0); add_slot(256, 0);
    add_slot(-1, 0); add_slot(1, 0); add_slot(9, 1);
    drain();

    // Widest range: the top value falls one past the usage count.
    write_reg(hak_pkg::REG_LOGICAL_MIN, -32768);
    write_reg(hak_pkg::REG_LOGICAL_MAX, 32767);
    write_reg(hak_pkg::REG_USAGE_COUNT, 65535);
    add_slot(-32768, 0); add_slot(32767, 1);
    drain();

    // Empty range with no usages: only the sync item comes out.
    write_reg(hak_pkg::REG_LOGICAL_MIN, 32767);
    write_reg(hak_pkg::REG_LOGICAL_MAX, -32768);
    write_reg(hak_pkg::REG_USAGE_COUNT, 0);
    add_slot(100, 1);
    drain();

    // Zero slots compare nothing; a count of seven acts as six.
    write_reg(hak_pkg::REG_LOGICAL_MIN, 0);
    write_reg(hak_pkg::REG_LOGICAL_MAX, 255);
    write_reg(hak_pkg::REG_USAGE_COUNT, 256);
    write_reg(hak_pkg::REG_SLOT_COUNT, 0);
    add_slot(3, 1);
    drain();
    write_reg(hak_pkg::REG_SLOT_COUNT, 7);
    add_slot(42, 1);
    drain();

    // Slot count lowered in the middle of a report.
    write_reg(hak_pkg::REG_SLOT_COUNT, 6);
    add_slot(10, 0); add_slot(11, 0); add_slot(12, 0); add_slot(13, 0);
    drain();
    write_reg(hak_pkg::REG_SLOT_COUNT, 2);
    add_slot(14, 1);
    drain();

    // Random phases, each with its own settings and idling pattern.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 52; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 52; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      random_config();
      start = queued;
      while (queued - start < PHASE_ITEMS) add_random_report();
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
